// ----- rtl/core/mse_pkg.sv -----
// Package: transaction types and instruction-set constants for the execute unit.
package mse_pkg;

  typedef struct packed {
    logic        action;
    logic [31:0] instr_word;
    logic [31:0] load_data;
  } in_t;

  typedef struct packed {
    logic [31:0] fetch_addr;
    logic [1:0]  bus_kind;
    logic [31:0] bus_addr;
    logic [31:0] bus_wdata;
    logic        status;
  } out_t;

  localparam logic [31:0] RESET_PC       = 32'hBFC0_0000;
  localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;
  localparam logic [31:0] PC_STEP        = 32'd4;
  localparam int unsigned LUI_SHIFT      = 16;

  localparam logic ACT_INSTR = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_OR  = 6'h25;

  localparam logic [4:0] COP_MT = 5'h04;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_READ  = 2'd1;
  localparam logic [1:0] BUS_WRITE = 2'd2;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_UNKNOWN = 1'b1;

endpackage

// ----- rtl/core/mips_subset_execute_unit.sv -----
// Top level: MIPS I subset execute unit with a one-instruction delay slot.
//
// Takes one transaction per clock and returns exactly one result per
// transaction, in the cycle after acceptance, from a registered output stage;
// in_ready stays high while the output register is empty or being drained,
// so the rate is one item per cycle unless out_ready stalls. The register
// file is a 32-entry memory with one write port and two registered read
// ports; the operands of an instruction are read when its word arrives
// (one instruction ahead of execution) and are forwarded from any write
// that lands before it executes. Register 0 reads as zero; entries not yet
// written read as zero through per-entry valid bits cleared by reset.
// Coprocessor 0 writes (MTC0) are accepted and reported as executed, but
// coprocessor state is not observable at the ports and is not stored.
module mips_subset_execute_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mse_pkg::out_t out_data
);

  // architectural state
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] held_r;
  logic [4:0]  load_dest_r, load_dest_nxt;
  logic        load_wait_r, load_wait_nxt;

  // register file and operand read ports
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] rd_a_r, rd_b_r;
  logic        vld_a_r, vld_b_r;
  logic        ovr_a_r, ovr_b_r;
  logic [31:0] ovr_a_val_r, ovr_b_val_r;

  logic          out_valid_r;
  mse_pkg::out_t out_data_r, out_nxt;

  logic        accept;
  logic        is_word;
  logic        wr_en;
  logic [4:0]  wr_idx;
  logic [31:0] wr_data;
  logic [4:0]  addr_a, addr_b;

  // decode of the held instruction
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, vs, vt, mem_addr;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_word   = (in_data.action == mse_pkg::ACT_INSTR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign op   = held_r[31:26];
  assign rs   = held_r[25:21];
  assign rt   = held_r[20:16];
  assign rd   = held_r[15:11];
  assign sh   = held_r[10:6];
  assign fn   = held_r[5:0];
  assign imm  = held_r[15:0];
  assign simm = {{16{imm[15]}}, imm};

  assign vs = ovr_a_r ? ovr_a_val_r : (vld_a_r ? rd_a_r : 32'd0);
  assign vt = ovr_b_r ? ovr_b_val_r : (vld_b_r ? rd_b_r : 32'd0);
  assign mem_addr = vs + simm;

  // read addresses: the incoming word's operands, else keep tracking the held ones
  assign addr_a = is_word ? in_data.instr_word[25:21] : rs;
  assign addr_b = is_word ? in_data.instr_word[20:16] : rt;

  always_comb begin
    logic       w_en;
    logic [4:0] w_idx;
    w_en          = 1'b0;
    w_idx         = '0;
    wr_data       = '0;
    pc_nxt        = pc_r;
    load_dest_nxt = load_dest_r;
    load_wait_nxt = load_wait_r;
    out_nxt       = '0;
    if (!is_word) begin
      if (load_wait_r) begin
        w_en          = 1'b1;
        w_idx         = load_dest_r;
        wr_data       = in_data.load_data;
        load_wait_nxt = 1'b0;
      end
    end else begin
      pc_nxt = pc_r + mse_pkg::PC_STEP;
      unique case (op)
        mse_pkg::OP_SPECIAL: begin
          if (fn == mse_pkg::FN_SLL) begin
            w_en = 1'b1; w_idx = rd; wr_data = vt << sh;
          end else if (fn == mse_pkg::FN_OR) begin
            w_en = 1'b1; w_idx = rd; wr_data = vs | vt;
          end else begin
            out_nxt.status = mse_pkg::ST_UNKNOWN;
          end
        end
        mse_pkg::OP_COP0: begin
          if (rs != mse_pkg::COP_MT) out_nxt.status = mse_pkg::ST_UNKNOWN;
        end
        mse_pkg::OP_J: begin
          pc_nxt = (pc_r & mse_pkg::PC_REGION_MASK) | {4'b0000, held_r[25:0], 2'b00};
        end
        mse_pkg::OP_BNE: begin
          if (vs != vt) pc_nxt = pc_r + {simm[29:0], 2'b00};
        end
        mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
          w_en = 1'b1; w_idx = rt; wr_data = vs + simm;
        end
        mse_pkg::OP_ORI: begin
          w_en = 1'b1; w_idx = rt; wr_data = vs | {16'd0, imm};
        end
        mse_pkg::OP_LUI: begin
          w_en = 1'b1; w_idx = rt; wr_data = {imm, 16'd0};
        end
        mse_pkg::OP_LW: begin
          out_nxt.bus_kind = mse_pkg::BUS_READ;
          out_nxt.bus_addr = mem_addr;
          load_dest_nxt    = rt;
          load_wait_nxt    = 1'b1;
        end
        mse_pkg::OP_SW: begin
          out_nxt.bus_kind  = mse_pkg::BUS_WRITE;
          out_nxt.bus_addr  = mem_addr;
          out_nxt.bus_wdata = vt;
        end
        default: out_nxt.status = mse_pkg::ST_UNKNOWN;
      endcase
    end
    out_nxt.fetch_addr = pc_nxt;
    // drop writes to register 0
    wr_en  = accept && w_en && (w_idx != 5'd0);
    wr_idx = w_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mse_pkg::RESET_PC;
      held_r      <= '0;
      load_dest_r <= '0;
      load_wait_r <= 1'b0;
      rf_vld_r    <= '0;
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      ovr_a_r     <= 1'b0;
      ovr_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pc_r        <= pc_nxt;
        load_dest_r <= load_dest_nxt;
        load_wait_r <= load_wait_nxt;
        if (is_word) begin
          held_r  <= in_data.instr_word;
          vld_a_r <= rf_vld_r[addr_a];
          vld_b_r <= rf_vld_r[addr_b];
          ovr_a_r <= wr_en && (wr_idx == addr_a);
          ovr_b_r <= wr_en && (wr_idx == addr_b);
        end else begin
          if (wr_en && (wr_idx == addr_a)) ovr_a_r <= 1'b1;
          if (wr_en && (wr_idx == addr_b)) ovr_b_r <= 1'b1;
        end
        if (wr_en) rf_vld_r[wr_idx] <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: register file, read data, forwarded values, result
  always_ff @(posedge clk) begin
    if (wr_en) rf_mem[wr_idx] <= wr_data;
    if (accept && is_word) begin
      rd_a_r <= rf_mem[addr_a];
      rd_b_r <= rf_mem[addr_b];
    end
    if (wr_en && (wr_idx == addr_a)) ovr_a_val_r <= wr_data;
    if (wr_en && (wr_idx == addr_b)) ovr_b_val_r <= wr_data;
    if (accept) out_data_r <= out_nxt;
  end

endmodule

// ----- rtl/core/mse_checker.sv -----
// Checker: port-level assertions for the execute unit, bound to the top level.
module mse_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input mse_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input mse_pkg::out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // every accepted transaction yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  // load data results make no bus request and report success
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == mse_pkg::ACT_LOAD) |=>
      (out_data.bus_kind == mse_pkg::BUS_NONE) && (out_data.bus_addr == 32'd0) &&
      (out_data.bus_wdata == 32'd0) && (out_data.status == mse_pkg::ST_OK))
    else $error("load data result not quiet");

  // fetch address stays word aligned
  a_pc_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fetch_addr[1:0] == 2'b00))
    else $error("misaligned fetch address");

  // a bus request never comes with an unknown-opcode status
  a_bus_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.bus_kind != mse_pkg::BUS_NONE) |->
      (out_data.status == mse_pkg::ST_OK) &&
      ((out_data.bus_kind == mse_pkg::BUS_READ) || (out_data.bus_kind == mse_pkg::BUS_WRITE)))
    else $error("bad bus kind or status");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (.*);
